// ===== rtl/xor_float_delta_encoder_top_macros.svh =====
// assertion macros for the xor float delta encoder
// used by the rtl files that carry concurrent checks; no other dependencies
`ifndef XOR_FLOAT_DELTA_ENCODER_TOP_MACROS_SVH
`define XOR_FLOAT_DELTA_ENCODER_TOP_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define XFD_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("xfd check failed");
// next-cycle implication
`define XFD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("xfd check failed");
`else
`define XFD_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define XFD_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/xfd_pkg.sv =====
// shared types, constants and bit-scan functions of the xor float delta encoder
// no dependencies; imported by every rtl module of the block
package xfd_pkg;

   localparam int VALUE_W = 64;
   localparam int CHUNK_W = 80;
   localparam int LEN_W   = 7;
   localparam int ACC_W   = 96;
   localparam int CNT_W   = 7;

   localparam logic [7:0]         HEADER_BYTE = 8'h10;
   localparam logic [VALUE_W-1:0] END_MARKER  = 64'h7FF8_0000_0000_0001;
   localparam logic [6:0]         LEAD_MASK   = 7'h1F;

   // request codes
   localparam logic REQ_ENCODE = 1'b0;
   localparam logic REQ_FINISH = 1'b1;

   // left-justified bit field handed from the front to the packer
   typedef struct packed {
      logic [CHUNK_W-1:0] bits;
      logic [LEN_W-1:0]   len;
      logic               fin;
   } chunk_type;

   // leading zero count, 64 for an all-zero word
   function automatic logic [6:0] clz64(input logic [VALUE_W-1:0] x);
      logic [6:0] n;
      n = 7'd64;
      for (int i = 0; i < VALUE_W; i++) begin
         if (x[i]) begin
            n = 7'(VALUE_W - 1 - i);
         end
      end
      return n;
   endfunction

   // trailing zero count, 64 for an all-zero word
   function automatic logic [6:0] ctz64(input logic [VALUE_W-1:0] x);
      logic [6:0] n;
      n = 7'd64;
      for (int i = VALUE_W - 1; i >= 0; i--) begin
         if (x[i]) begin
            n = 7'(i);
         end
      end
      return n;
   endfunction

endpackage

// ===== rtl/xfd_channels.sv =====
// valid/ready channel interfaces of the xor float delta encoder
// no dependencies; used by the top level, the front and the packer
interface xfd_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [63:0] sample_bits;

   modport source (output valid, output req_type, output sample_bits, input ready);
   modport sink   (input valid, input req_type, input sample_bits, output ready);
endinterface

interface xfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       stream_end;

   modport source (output valid, output out_byte, output run_last, output stream_end,
                   input ready);
   modport sink   (input valid, input out_byte, input run_last, input stream_end,
                   output ready);
endinterface

// ===== rtl/xfd_front.sv =====
// front end: accepts request words, scans the xor delta and builds the bit field
// depends on xfd_pkg, xfd_channels and the assertion macro header
`include "xor_float_delta_encoder_top_macros.svh"

module xfd_front (
   input  logic              clock,
   input  logic              reset,
   xfd_req_if.sink           req_ch,
   input  logic              q_full,
   output logic              q_push,
   output xfd_pkg::chunk_type q_chunk
);
   import xfd_pkg::*;

   localparam logic [LEN_W-1:0] FIRST_LEN = 7'd72;
   localparam logic [LEN_W-1:0] ZERO_LEN  = 7'd1;
   localparam logic [LEN_W-1:0] REUSE_OFS = 7'd66;
   localparam logic [LEN_W-1:0] NEW_HDR   = 7'd13;
   localparam logic [LEN_W-1:0] FULL_LEN  = 7'd64;

   logic en;
   logic accept;
   logic take;
   logic [VALUE_W-1:0] sample_sel;

   logic               prev_first_ff;
   logic               stream_done_ff;
   logic [VALUE_W-1:0] prev_value_ff;

   logic               s1_valid_ff;
   logic               s1_fin_ff;
   logic               s1_first_ff;
   logic [VALUE_W-1:0] s1_value_ff;
   logic [VALUE_W-1:0] s1_delta_ff;

   logic               s2_valid_ff;
   logic               s2_fin_ff;
   logic               s2_first_ff;
   logic               s2_zero_ff;
   logic [VALUE_W-1:0] s2_value_ff;
   logic [VALUE_W-1:0] s2_delta_ff;
   logic [4:0]         s2_lead_ff;
   logic [5:0]         s2_trail_ff;

   logic       window_valid_ff;
   logic [4:0] window_leading_ff;
   logic [5:0] window_trailing_ff;

   logic [6:0]       lead_full;
   logic [6:0]       trail_full;
   logic             reuse;
   logic             new_window;
   logic [LEN_W-1:0] mean_len;

   // the whole front moves together while the queue has room
   assign en            = !q_full;
   assign req_ch.ready  = en;
   assign accept        = req_ch.valid && en;
   assign take          = accept && !stream_done_ff;
   assign sample_sel    = (req_ch.req_type == REQ_FINISH) ? END_MARKER : req_ch.sample_bits;

   // bit scans of the registered delta
   assign lead_full  = clz64(s1_delta_ff) & LEAD_MASK;
   assign trail_full = ctz64(s1_delta_ff);

   // window choice against the stored window
   assign reuse = window_valid_ff && (s2_lead_ff > window_leading_ff)
                  && (s2_trail_ff >= window_trailing_ff);
   assign new_window = s2_valid_ff && !s2_first_ff && !s2_zero_ff && !reuse;
   assign mean_len   = FULL_LEN - {2'b00, s2_lead_ff} - {1'b0, s2_trail_ff};

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff        <= 1'b0;
         s2_valid_ff        <= 1'b0;
         prev_value_ff      <= '0;
         prev_first_ff      <= 1'b1;
         stream_done_ff     <= 1'b0;
         window_valid_ff    <= 1'b0;
         window_leading_ff  <= '0;
         window_trailing_ff <= '0;
      end else if (en) begin
         s1_valid_ff <= take;
         s2_valid_ff <= s1_valid_ff;
         if (take) begin
            prev_value_ff  <= sample_sel;
            prev_first_ff  <= 1'b0;
            stream_done_ff <= (req_ch.req_type == REQ_FINISH);
         end
         if (new_window) begin
            window_valid_ff    <= 1'b1;
            window_leading_ff  <= s2_lead_ff;
            window_trailing_ff <= s2_trail_ff;
         end
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (en) begin
         s1_fin_ff   <= (req_ch.req_type == REQ_FINISH);
         s1_first_ff <= prev_first_ff;
         s1_value_ff <= sample_sel;
         s1_delta_ff <= sample_sel ^ prev_value_ff;
         s2_fin_ff   <= s1_fin_ff;
         s2_first_ff <= s1_first_ff;
         s2_zero_ff  <= (s1_delta_ff == '0);
         s2_value_ff <= s1_value_ff;
         s2_delta_ff <= s1_delta_ff;
         s2_lead_ff  <= lead_full[4:0];
         s2_trail_ff <= trail_full[5:0];
      end
   end

   // bit field, left-justified, and its length
   always_comb begin
      q_chunk.fin = s2_fin_ff;
      if (s2_first_ff) begin
         q_chunk.bits = {HEADER_BYTE, s2_value_ff, 8'h00};
         q_chunk.len  = FIRST_LEN;
      end else if (s2_zero_ff) begin
         q_chunk.bits = '0;
         q_chunk.len  = ZERO_LEN;
      end else if (reuse) begin
         q_chunk.bits = {2'b10, s2_delta_ff << window_leading_ff, 14'h0000};
         q_chunk.len  = REUSE_OFS - {2'b00, window_leading_ff} - {1'b0, window_trailing_ff};
      end else begin
         q_chunk.bits = {2'b11, s2_lead_ff, mean_len[5:0], s2_delta_ff << s2_lead_ff, 3'b000};
         q_chunk.len  = mean_len + NEW_HDR;
      end
   end

   assign q_push = s2_valid_ff && en;

   `XFD_ASSERT_NEXT(a_no_word_after_done, clock, reset, stream_done_ff && en, !s1_valid_ff)

endmodule

// ===== rtl/xfd_queue.sv =====
// short queue of bit fields between the front and the packer
// depends on xfd_pkg and the assertion macro header
`include "xor_float_delta_encoder_top_macros.svh"

module xfd_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  xfd_pkg::chunk_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output xfd_pkg::chunk_type head
);
   import xfd_pkg::*;

   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int QCNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]  LAST_PTR   = PTR_W'(DEPTH - 1);
   localparam logic [QCNT_W-1:0] FULL_COUNT = QCNT_W'(DEPTH);

   chunk_type         entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   assign full      = (count_ff == FULL_COUNT);
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   // occupancy
   always_comb begin
      count_in = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `XFD_ASSERT_IMPLY(a_no_push_when_full, clock, reset, count_ff == FULL_COUNT, !push)
   `XFD_ASSERT_IMPLY(a_no_pop_when_empty, clock, reset, count_ff == '0, !pop)

endmodule

// ===== rtl/xfd_packer.sv =====
// back end: appends bit fields to the bit accumulator and sends whole bytes
// depends on xfd_pkg, xfd_channels and the assertion macro header
`include "xor_float_delta_encoder_top_macros.svh"

module xfd_packer (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  xfd_pkg::chunk_type q_head,
   output logic               q_pop,
   xfd_rsp_if.source          rsp_ch
);
   import xfd_pkg::*;

   localparam logic [CNT_W-1:0] BYTE_BITS = 7'd8;
   localparam logic [CNT_W-1:0] TWO_BYTES = 7'd16;
   localparam logic [CNT_W-1:0] PAD_ADD   = 7'd7;
   localparam logic [CNT_W-1:0] BYTE_MASK = 7'b111_1000;
   localparam int               FILL_W    = ACC_W - CHUNK_W;

   logic [ACC_W-1:0] acc_ff;
   logic [ACC_W-1:0] acc_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             fin_ff;
   logic             fin_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [7:0]       rsp_byte_ff;
   logic             rsp_last_ff;
   logic             rsp_end_ff;

   logic             out_free;
   logic             emit;
   logic             last_byte;
   logic [CNT_W-1:0] sum;
   logic [CNT_W-1:0] padded;

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign emit      = (cnt_ff >= BYTE_BITS) && out_free;
   assign q_pop     = (cnt_ff < BYTE_BITS) && q_valid;
   assign last_byte = (cnt_ff < TWO_BYTES);

   // fill level after a load; a finish rounds up and adds the closing zero byte
   assign sum    = cnt_ff + q_head.len;
   assign padded = ((sum + PAD_ADD) & BYTE_MASK) + BYTE_BITS;

   // accumulator next state
   always_comb begin
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      fin_in = fin_ff;
      if (q_pop) begin
         acc_in = acc_ff | ({q_head.bits, {FILL_W{1'b0}}} >> cnt_ff);
         cnt_in = q_head.fin ? padded : sum;
         fin_in = q_head.fin;
      end else if (emit) begin
         acc_in = acc_ff << BYTE_BITS;
         cnt_in = cnt_ff - BYTE_BITS;
      end
   end

   // output register handshake
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output word
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_byte_ff <= acc_ff[ACC_W-1 -: 8];
         rsp_last_ff <= last_byte;
         rsp_end_ff  <= fin_ff && last_byte;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_byte   = rsp_byte_ff;
   assign rsp_ch.run_last   = rsp_last_ff;
   assign rsp_ch.stream_end = rsp_end_ff;

   `XFD_ASSERT_IMPLY(a_end_is_last, clock, reset, rsp_valid_ff && rsp_end_ff, rsp_last_ff)
   `XFD_ASSERT_NEXT(a_end_drains_acc, clock, reset, emit && fin_ff && last_byte, cnt_ff == '0)

endmodule

// ===== rtl/xor_float_delta_encoder_top.sv =====
// top level of the xor float delta encoder
// depends on xfd_pkg, xfd_channels, xfd_front, xfd_queue and xfd_packer
//
// usage:
//   req_ch carries one word per value: req_type 0 encodes sample_bits, req_type 1
//   finishes the stream (end marker, zero padding, one closing zero byte).
//   rsp_ch returns the compressed stream one byte per word, msb first; run_last
//   marks the last byte a request caused and stream_end the closing byte.
//   a request that completes no byte returns nothing.
// path: a request's first byte goes through the two scan stages, the queue,
//   the packer load and the output register when the packer is idle.
// packing: the packer loads a request's bit field, then sends its bytes while
//   rsp_ch.ready allows and loads the next field once fewer than eight bits remain;
//   the front takes a word every cycle while the queue has room.
// reset: synchronous; the stream restarts with the header byte on the next value.
//   after a finish, words are still accepted but dropped until reset.
// stall: a held rsp_ch.ready keeps the output byte; the queue of QUEUE_DEPTH
//   fields fills and then req_ch.ready drops.
module xor_float_delta_encoder_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   xfd_req_if.sink   req_ch,
   xfd_rsp_if.source rsp_ch
);
   import xfd_pkg::*;

   logic      q_full;
   logic      q_push;
   logic      q_pop;
   logic      q_valid;
   chunk_type push_chunk;
   chunk_type head_chunk;

   // classify and build bit fields
   xfd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_chunk (push_chunk)
   );

   // decoupling queue
   xfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_chunk),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head      (head_chunk)
   );

   // byte packing and output register
   xfd_packer u_packer (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_head  (head_chunk),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

// ===== tb/tb_xor_float_delta_encoder_top.sv =====
// self-checking testbench for the xor float delta encoder top level
// needs xfd_pkg, xfd_channels and the rtl of xor_float_delta_encoder_top
// a byte-stream predictor mirrors the encoder; a driver and a monitor apply random idling
`timescale 1ns / 100ps

module tb_xor_float_delta_encoder_top;
   import xfd_pkg::*;

   localparam int RANDOM_WORDS   = 240;
   localparam int TAIL_CYCLES    = 40;

   typedef struct packed {
      logic        req_type;
      logic [63:0] sample_bits;
   } sample_word_type;

   typedef struct {
      logic [7:0] out_byte;
      logic       run_last;
      logic       stream_end;
   } stream_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   xfd_req_if req_ch ();
   xfd_rsp_if rsp_ch ();

   xor_float_delta_encoder_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // words waiting for the driver and bytes waiting for the monitor
   sample_word_type pending_words_q[$];
   stream_byte_type expected_bytes_q[$];
   sample_word_type next_word;

   int unsigned words_sent;
   int unsigned total_words;
   int unsigned mismatch_count;

   // mirror of the encoder state
   logic [63:0] last_value;
   bit          header_due;
   bit          win_valid;
   logic [4:0]  win_lead;
   logic [5:0]  win_trail;
   logic [7:0]  pend_byte;
   int unsigned pend_free;
   bit          closed;

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned count_top_zeros(logic [63:0] x);
      int unsigned n = 0;
      while (n < 64 && !x[63-n]) n++;
      return n;
   endfunction

   function automatic int unsigned count_bottom_zeros(logic [63:0] x);
      int unsigned n = 0;
      while (n < 64 && !x[n]) n++;
      return n;
   endfunction

   function automatic void emit_byte(logic [7:0] b, logic closing);
      stream_byte_type e;
      e.out_byte   = b;
      e.run_last   = 1'b0;
      e.stream_end = closing;
      expected_bytes_q.push_back(e);
   endfunction

   // msb-first bit packer, a full byte goes to the expectation store
   function automatic void shift_bit(logic b);
      if (b) pend_byte[pend_free-1] = 1'b1;
      pend_free--;
      if (pend_free == 0) begin
         emit_byte(pend_byte, 1'b0);
         pend_byte = 8'h00;
         pend_free = 8;
      end
   endfunction

   function automatic void shift_field(logic [63:0] v, int unsigned n);
      for (int i = n; i > 0; i--) shift_bit(v[i-1]);
   endfunction

   // one value: header and raw bits first, then xor deltas
   function automatic void encode_value(logic [63:0] v);
      logic [63:0] delta;
      int unsigned lead, trail, len;
      if (header_due) begin
         shift_field(64'(HEADER_BYTE), 8);
         shift_field(v, 64);
         last_value = v;
         header_due = 1'b0;
         return;
      end
      delta = v ^ last_value;
      if (delta == '0) begin
         shift_bit(1'b0);
         return;
      end
      shift_bit(1'b1);
      lead  = count_top_zeros(delta) & LEAD_MASK;
      trail = count_bottom_zeros(delta);
      if (win_valid && lead > win_lead && trail >= win_trail) begin
         // meaningful bits fit the stored window
         shift_bit(1'b0);
         len = 64 - win_lead - win_trail;
         shift_field(delta >> win_trail, len);
      end else begin
         // new window: leading count, length mod 64, bits
         win_valid = 1'b1;
         win_lead  = lead[4:0];
         win_trail = trail[5:0];
         shift_bit(1'b1);
         shift_field(64'(lead), 5);
         len = 64 - lead - trail;
         shift_field(64'(len), 6);
         shift_field(delta >> trail, len);
      end
      last_value = v;
   endfunction

   function automatic void predict_stream_bytes(logic kind, logic [63:0] bits);
      int unsigned start_size;
      start_size = expected_bytes_q.size();
      if (closed) return;
      if (kind == REQ_ENCODE) begin
         encode_value(bits);
      end else begin
         // end marker, zero padding, closing zero byte
         encode_value(END_MARKER);
         while (pend_free != 8) shift_bit(1'b0);
         emit_byte(8'h00, 1'b1);
         closed = 1'b1;
      end
      if (expected_bytes_q.size() > start_size)
         expected_bytes_q[expected_bytes_q.size()-1].run_last = 1'b1;
   endfunction

   function automatic void check_stream_byte(logic [7:0] b, logic last, logic closing);
      stream_byte_type e;
      if (expected_bytes_q.size() == 0) begin
         mismatch_count++;
         $display("%0t: unexpected word byte=%h run_last=%b stream_end=%b",
                  $time, b, last, closing);
         return;
      end
      e = expected_bytes_q.pop_front();
      if (e.out_byte !== b || e.run_last !== last || e.stream_end !== closing) begin
         mismatch_count++;
         $display("%0t: expected byte=%h run_last=%b stream_end=%b,",
                  $time, e.out_byte, e.run_last, e.stream_end,
                  " got byte=%h run_last=%b stream_end=%b", b, last, closing);
      end
   endfunction

   // idling by thirds of the run: sender-light, receiver-light, none
   function automatic int unsigned sender_idle_pct();
      if (words_sent * 3 < total_words) return 28;
      else if (words_sent * 3 < total_words * 2) return 45;
      else return 0;
   endfunction

   function automatic int unsigned receiver_idle_pct();
      if (words_sent * 3 < total_words) return 45;
      else if (words_sent * 3 < total_words * 2) return 28;
      else return 0;
   endfunction

   function automatic logic [63:0] span_mask(int unsigned hi, int unsigned lo);
      logic [63:0] m;
      m = '0;
      for (int i = lo; i <= hi; i++) m[i] = 1'b1;
      return m;
   endfunction

   // stimulus generation keeps its own running value
   logic [63:0] gen_value;

   function automatic void queue_value(logic [63:0] v);
      sample_word_type w;
      w.req_type    = REQ_ENCODE;
      w.sample_bits = v;
      gen_value     = v;
      pending_words_q.push_back(w);
   endfunction

   function automatic void queue_delta(logic [63:0] d);
      queue_value(gen_value ^ d);
   endfunction

   // driver: predicts on acceptance, then offers the next word
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_stream_bytes(req_ch.req_type, req_ch.sample_bits);
            words_sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_words_q.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
               next_word = pending_words_q.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.req_type    <= next_word.req_type;
               req_ch.sample_bits <= next_word.sample_bits;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each accepted byte, stalls at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            check_stream_byte(rsp_ch.out_byte, rsp_ch.run_last, rsp_ch.stream_end);
         rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
      end
   end

   // stimulus and end of run
   initial begin
      sample_word_type w;
      logic [63:0]     delta;
      int unsigned     pick, span_hi, span_lo, inner_hi;

      req_ch.valid       = 1'b0;
      req_ch.req_type    = REQ_ENCODE;
      req_ch.sample_bits = '0;
      rsp_ch.ready       = 1'b0;
      words_sent     = 0;
      mismatch_count = 0;
      last_value = '0;
      header_due = 1'b1;
      win_valid  = 1'b0;
      win_lead   = '0;
      win_trail  = '0;
      pend_byte  = 8'h00;
      pend_free  = 8;
      closed     = 1'b0;

      // directed: field extremes, both window forms, masked leading count
      queue_value(64'hFFFF_FFFF_FFFF_FFFF);
      queue_delta(64'h0);
      queue_delta(64'hFFFF_FFFF_FFFF_FFFF);
      queue_delta(64'h8000_0000_0000_0000);
      queue_delta(64'h0000_0000_0000_0001);
      queue_delta(64'h0000_0000_8000_0000);
      queue_delta(64'h1FFF_FFFF_FFFF_FFF0);
      queue_delta(64'h0007_0000_0000_0100);
      queue_delta(64'h0000_0100_0000_0010);
      // equal leading count forces a new window, then a smaller trailing count
      queue_delta(64'h1000_0000_0000_0100);
      queue_delta(64'h0100_0000_0000_0010);
      queue_delta(64'h0);
      queue_value(64'h3FF0_0000_0000_0000);
      queue_value(64'h4000_0000_0000_0000);
      queue_value(64'h4000_0000_0000_0000);
      queue_value(END_MARKER);
      queue_value(64'h7FF0_0000_0000_0000);
      queue_value(64'h8000_0000_0000_0000);
      queue_delta(64'h0000_0000_0000_0003);

      // random: windows opened by an edge-exact delta, then narrower deltas and noise
      span_hi = 63;
      span_lo = 0;
      for (int k = 0; k < RANDOM_WORDS; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            span_hi = $urandom_range(0, 63);
            span_lo = $urandom_range(0, span_hi);
            delta = ({$urandom, $urandom} & span_mask(span_hi, span_lo))
                    | (64'd1 << span_hi) | (64'd1 << span_lo);
         end else if (pick < 27) begin
            delta = '0;
         end else if (pick < 37) begin
            delta = {$urandom, $urandom};
         end else if (span_hi > span_lo) begin
            inner_hi = $urandom_range(span_lo, span_hi - 1);
            delta = ({$urandom, $urandom} & span_mask(inner_hi, span_lo))
                    | (64'd1 << inner_hi);
         end else begin
            delta = 64'd1 << span_lo;
         end
         queue_delta(delta);
      end

      // finish, then a few words that the closed stream drops
      w.req_type    = REQ_FINISH;
      w.sample_bits = {$urandom, $urandom};
      pending_words_q.push_back(w);
      total_words = pending_words_q.size();
      for (int k = 0; k < 4; k++) begin
         w.req_type    = 1'($urandom_range(0, 1));
         w.sample_bits = {$urandom, $urandom};
         pending_words_q.push_back(w);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_words_q.size() != 0 || req_ch.valid) @(posedge clock);
      while (expected_bytes_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // hang guard
   initial begin
      #1000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/xfd_pkg.sv
rtl/xfd_channels.sv
rtl/xfd_front.sv
rtl/xfd_queue.sv
rtl/xfd_packer.sv
rtl/xor_float_delta_encoder_top.sv
tb/tb_xor_float_delta_encoder_top.sv
